// ===== design/clf4_pkg.sv =====
// Shared types and constants for the CR LF line framer with four line slots.
`default_nettype none

package clf4_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_W     = 2;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_COPY_END,
    ST_RD_ADDR,
    ST_RD_WAIT,
    ST_RD_NONE
  } state_t;

  typedef struct packed {
    logic req_ready;
    logic copy_step;
    logic rd_issue;
    logic rd_load;
    logic none_load;
  } cmd_t;

  typedef struct packed {
    logic req_valid;
    logic req_read;
    logic commit;
    logic any_ready;
    logic copy_last;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/clf4_in_if.sv =====
// Request channel: received bytes and line read requests.
`default_nettype none

interface clf4_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/clf4_out_if.sv =====
// Response channel: bytes of a returned line.
`default_nettype none

interface clf4_out_if;
  logic       valid;
  logic       ready;
  logic       line_ready;
  logic [1:0] slot_index;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output line_ready, output slot_index, output out_byte,
                  output last, input ready);
  modport sink (input valid, input line_ready, input slot_index, input out_byte,
                input last, output ready);
endinterface

`default_nettype wire

// ===== design/clf4_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module clf4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/clf4_ctrl.sv =====
// Controller state machine: sequences byte intake, line commit copy and line reads.
`default_nettype none

module clf4_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  clf4_pkg::sts_t sts,
  output clf4_pkg::cmd_t cmd
);

  import clf4_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sts.req_valid) begin
          if (sts.req_read) begin
            state_next = sts.any_ready ? ST_RD_ADDR : ST_RD_NONE;
          end else if (sts.commit) begin
            state_next = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        if (sts.copy_last) begin
          state_next = ST_COPY_END;
        end
      end
      ST_COPY_END: state_next = ST_IDLE;
      ST_RD_ADDR:  state_next = ST_RD_WAIT;
      ST_RD_WAIT: begin
        if (sts.out_free) begin
          state_next = sts.rd_last ? ST_IDLE : ST_RD_ADDR;
        end
      end
      ST_RD_NONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:     cmd.req_ready = 1'b1;
      ST_COPY:     cmd.copy_step = 1'b1;
      ST_COPY_END: cmd = '0;
      ST_RD_ADDR:  cmd.rd_issue = 1'b1;
      ST_RD_WAIT:  cmd.rd_load = sts.out_free;
      ST_RD_NONE:  cmd.none_load = sts.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/clf4_dp.sv =====
// Datapath: line buffer, slot store, slot bookkeeping and output register.
`default_nettype none

module clf4_dp #(
  parameter int LINE_BYTES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  clf4_pkg::cmd_t cmd,
  output clf4_pkg::sts_t sts,
  input  logic           req_valid,
  input  logic           req_kind,
  input  logic [7:0]     req_byte,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_line_ready,
  output logic [1:0]     out_slot_index,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  import clf4_pkg::*;

  localparam int IDX_W = $clog2(LINE_BYTES);
  localparam int CNT_W = $clog2(LINE_BYTES + 1);
  localparam int SA_W  = IDX_W + SLOT_W;
  localparam int SLOT_DEPTH = SLOT_COUNT << IDX_W;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(LINE_BYTES);

  logic [CNT_W-1:0]  fill;
  logic [7:0]        prev;
  logic [CNT_W-1:0]  slot_len [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_rdy;
  logic [SLOT_W-1:0] next_slot;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  copy_len;
  logic [SLOT_W-1:0] copy_slot;
  logic [CNT_W-1:0]  rd_len;
  logic [SLOT_W-1:0] rd_slot;
  logic              wr_pend;
  logic [IDX_W-1:0]  wr_idx;

  logic              accept;
  logic              acc_byte;
  logic              acc_read;
  logic              room;
  logic [CNT_W-1:0]  fill_next;
  logic [SLOT_W-1:0] sel;
  logic [7:0]        line_rdata;
  logic [7:0]        slot_rdata;
  logic [CNT_W-1:0]  idx_inc;

  assign accept    = req_valid && cmd.req_ready;
  assign acc_byte  = accept && (req_kind == KIND_BYTE);
  assign acc_read  = accept && (req_kind == KIND_READ);
  assign room      = (fill < FULL);
  assign fill_next = room ? fill + CNT_W'(1) : fill;
  assign idx_inc   = CNT_W'(idx) + CNT_W'(1);

  always_comb begin
    sel = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (slot_rdy[s]) begin
        sel = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    sts.req_valid = req_valid;
    sts.req_read  = (req_kind == KIND_READ);
    sts.commit    = (req_kind == KIND_BYTE) && (req_byte == BYTE_LF) && (prev == BYTE_CR);
    sts.any_ready = |slot_rdy;
    sts.copy_last = (idx_inc == copy_len);
    sts.rd_last   = (idx_inc == rd_len);
    sts.out_free  = !out_valid || out_ready;
  end

  clf4_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk   (clk),
    .we    (acc_byte && room),
    .waddr (fill[IDX_W-1:0]),
    .wdata (req_byte),
    .re    (cmd.copy_step),
    .raddr (idx),
    .rdata (line_rdata)
  );

  clf4_ram #(
    .WIDTH (8),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (wr_pend),
    .waddr (SA_W'({copy_slot, wr_idx})),
    .wdata (line_rdata),
    .re    (cmd.rd_issue),
    .raddr (SA_W'({rd_slot, idx})),
    .rdata (slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      prev      <= '0;
      slot_rdy  <= '0;
      next_slot <= '0;
      wr_pend   <= 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        slot_len[s] <= '0;
      end
    end else begin
      wr_pend <= cmd.copy_step;
      if (acc_byte) begin
        prev <= req_byte;
        if (sts.commit) begin
          fill                <= '0;
          slot_len[next_slot] <= fill_next;
          slot_rdy[next_slot] <= 1'b1;
          next_slot           <= next_slot + SLOT_W'(1);
        end else begin
          fill <= fill_next;
        end
      end
      if (acc_read && sts.any_ready) begin
        slot_rdy[sel] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_idx <= idx;
    if (acc_byte && sts.commit) begin
      copy_len  <= fill_next;
      copy_slot <= next_slot;
      idx       <= '0;
    end
    if (acc_read) begin
      rd_len  <= slot_len[sel];
      rd_slot <= sel;
      idx     <= '0;
    end
    if (cmd.copy_step || cmd.rd_load) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.rd_load || cmd.none_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_load) begin
      out_line_ready <= 1'b1;
      out_slot_index <= rd_slot;
      out_byte       <= slot_rdata;
      out_last       <= sts.rd_last;
    end else if (cmd.none_load) begin
      out_line_ready <= 1'b0;
      out_slot_index <= '0;
      out_byte       <= '0;
      out_last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/crlf_line_framer_four_slot_core.sv =====
// Top level of the CR LF line framer with four round-robin line slots.
//
//   channel | dir | beat contents
//   --------+-----+-------------------------------------------------
//   req     | in  | kind (0 byte, 1 read), rx_byte
//   rsp     | out | line_ready, slot_index, out_byte, last
//
// A received byte is written to the line buffer while it has room; a CR LF commit then copies the line into its
// slot at one byte per cycle.
// A read fetches each byte from the slot store before it loads the rsp beat; one beat if empty.
// rst is synchronous; no clearing pass is needed after reset.
// A stalled rsp holds the current beat; req is not taken during a copy or a read.
`default_nettype none

module crlf_line_framer_four_slot_core #(
  parameter int LINE_BYTES = 64
) (
  input logic       clk,
  input logic       rst,
  clf4_in_if.sink   req,
  clf4_out_if.source rsp
);

  import clf4_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign req.ready = cmd.req_ready;

  clf4_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  clf4_dp #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_valid      (req.valid),
    .req_kind       (req.kind),
    .req_byte       (req.rx_byte),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_line_ready (rsp.line_ready),
    .out_slot_index (rsp.slot_index),
    .out_byte       (rsp.out_byte),
    .out_last       (rsp.last)
  );

endmodule

`default_nettype wire

// ===== tb/tb_crlf_line_framer_four_slot_core.sv =====
// Testbench for the CR LF line framer with four slots: directed and random byte and read traffic, scoreboard.
`timescale 1ns / 1ps

module tb_crlf_line_framer_four_slot_core;
  import clf4_pkg::*;

  localparam int LINE_BYTES = 64;
  localparam int RANDOM_ITEMS = 480;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } req_item_t;

  typedef struct packed {
    logic       line_ready;
    logic [1:0] slot_index;
    logic [7:0] out_byte;
    logic       last;
  } line_beat_t;

  logic clk;
  logic rst;

  clf4_in_if  req_ch ();
  clf4_out_if rsp_ch ();

  crlf_line_framer_four_slot_core #(
    .LINE_BYTES(LINE_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  req_item_t  pending_reqs[$];
  line_beat_t line_beats_due[$];

  logic [7:0] rx_line [LINE_BYTES];
  int         rx_fill;
  logic [7:0] rx_prev;
  logic [7:0] slot_store [SLOT_COUNT][LINE_BYTES];
  int         slot_len [SLOT_COUNT];
  logic       slot_waiting [SLOT_COUNT];
  logic [1:0] commit_slot;

  int issued;
  int accepted;
  int fail_count;
  int burst_left;
  int gap_left;
  logic [7:0] stall_pat;
  logic [5:0] stall_tick;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic push_rx(input logic [7:0] b);
    pending_reqs.push_back('{KIND_BYTE, b});
  endtask

  task automatic push_read();
    pending_reqs.push_back('{KIND_READ, 8'($urandom)});
  endtask

  task automatic push_random_segment();
    int len;
    int pick;
    int reads;
    pick = $urandom_range(0, 15);
    len = (pick == 0) ? $urandom_range(58, 70) : $urandom_range(0, 12);
    if (pick == 1) begin
      push_rx(BYTE_LF);
      push_rx(8'($urandom));
    end else if (pick == 2) begin
      push_rx(BYTE_CR);
      push_rx(8'($urandom_range(0, 9)));
    end else begin
      repeat (len) push_rx(8'($urandom));
      push_rx(BYTE_CR);
      push_rx(BYTE_LF);
    end
    reads = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(0, 2);
    repeat (reads) push_read();
  endtask

  task automatic predict_line_beats(input req_item_t it);
    int s;
    int i;
    bit hit;
    logic after_cr;
    hit = 1'b0;
    if (it.kind == KIND_READ) begin
      for (s = 0; s < SLOT_COUNT; s++) begin
        if (!hit && slot_waiting[s]) begin
          hit = 1'b1;
          slot_waiting[s] = 1'b0;
          if (slot_len[s] == 0) begin
            line_beats_due.push_back('{1'b1, 2'(s), 8'h00, 1'b1});
          end else begin
            for (i = 0; i < slot_len[s]; i++)
              line_beats_due.push_back('{1'b1, 2'(s), slot_store[s][i],
                                         (i + 1 == slot_len[s])});
          end
        end
      end
      if (!hit) line_beats_due.push_back('{1'b0, 2'd0, 8'h00, 1'b1});
    end else begin
      after_cr = (rx_prev == BYTE_CR);
      if (rx_fill < LINE_BYTES) begin
        rx_line[rx_fill] = it.rx_byte;
        rx_fill++;
      end
      rx_prev = it.rx_byte;
      if (it.rx_byte == BYTE_LF && after_cr) begin
        for (i = 0; i < rx_fill; i++) slot_store[commit_slot][i] = rx_line[i];
        slot_len[commit_slot] = rx_fill;
        slot_waiting[commit_slot] = 1'b1;
        rx_fill = 0;
        commit_slot = commit_slot + 2'd1;
      end
    end
  endtask

  task automatic report_beat(input string what, input line_beat_t want, input line_beat_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected ready=%0d slot=%0d byte=%02h last=%0d, got ready=%0d slot=%0d byte=%02h last=%0d",
               $time, what, want.line_ready, want.slot_index, want.out_byte, want.last,
               got.line_ready, got.slot_index, got.out_byte, got.last);
  endtask

  // Accept request beats into the predictor and check response beats.
  always @(posedge clk) begin : monitor
    line_beat_t got;
    line_beat_t want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        predict_line_beats('{req_ch.kind, req_ch.rx_byte});
        accepted <= accepted + 1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = '{rsp_ch.line_ready, rsp_ch.slot_index, rsp_ch.out_byte, rsp_ch.last};
        if (line_beats_due.size() == 0) begin
          report_beat("unexpected beat", '0, got);
        end else begin
          want = line_beats_due.pop_front();
          if (got !== want) report_beat("mismatch", want, got);
        end
      end
    end
  end

  // Send requests in bursts; hold a beat until it is taken.
  always @(negedge clk) begin : driver
    req_item_t item;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && accepted != issued) begin
    end else if (gap_left > 0) begin
      req_ch.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_reqs.size() != 0) begin
      item = pending_reqs.pop_front();
      req_ch.kind <= item.kind;
      req_ch.rx_byte <= item.rx_byte;
      req_ch.valid <= 1'b1;
      issued <= issued + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Stall the response side on a rotating pattern, reloaded each time stall_tick wraps.
  always @(negedge clk) begin : stall
    logic [7:0] pat;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_pat <= 8'hFF;
      stall_tick <= 6'd0;
    end else begin
      pat = stall_pat;
      if (stall_tick == 6'd0) begin
        case ($urandom_range(0, 3))
          0: pat = 8'hFF;
          1: pat = 8'($urandom);
          2: pat = 8'h01 << $urandom_range(0, 7);
          default: pat = 8'($urandom) | 8'($urandom);
        endcase
        if (pat == 8'h00) pat = 8'h80;
      end
      rsp_ch.ready <= pat[0];
      stall_pat <= {pat[0], pat[7:1]};
      stall_tick <= stall_tick + 6'd1;
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int base;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.kind = KIND_BYTE;
    req_ch.rx_byte = 8'h00;
    rsp_ch.ready = 1'b0;
    rx_fill = 0;
    rx_prev = 8'h00;
    commit_slot = 2'd0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      slot_len[s] = 0;
      slot_waiting[s] = 1'b0;
    end
    issued = 0;
    accepted = 0;
    fail_count = 0;
    burst_left = 0;
    gap_left = 0;
    stall_pat = 8'hFF;
    stall_tick = 6'd0;

    push_read();
    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(BYTE_CR);
    push_rx(BYTE_LF);
    push_read();
    push_read();
    push_rx(BYTE_LF);
    push_rx(BYTE_CR);
    push_rx(8'h41);
    push_rx(BYTE_LF);
    push_rx(BYTE_CR);
    push_read();
    push_rx(BYTE_LF);
    push_read();
    push_rx(BYTE_CR);
    push_rx(BYTE_CR);
    push_rx(BYTE_LF);
    push_read();
    push_rx(8'h55);
    push_rx(8'hAA);
    push_rx(BYTE_CR);
    push_rx(BYTE_LF);
    push_read();
    push_read();

    base = pending_reqs.size();
    while (pending_reqs.size() - base < RANDOM_ITEMS) push_random_segment();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || accepted != issued || line_beats_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (line_beats_due.size() != 0) begin
      fail_count++;
      $display("%0d expected beats never arrived", line_beats_due.size());
    end
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
